// ----- rtl/core/cpt_bank_pkg.sv -----
package cpt_bank_pkg;

    localparam int NUM_TIMERS  = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int PRESC_W     = 10;
    localparam int PULSE_W     = 4;
    localparam int DELAY_W     = 2;
    localparam int EXT_W       = 32;

    localparam logic [7:0] CTRL_MASK_FIRST = 8'hC3;
    localparam logic [7:0] CTRL_MASK_REST  = 8'hC7;
    localparam int CTRL_EN_BIT  = 7;
    localparam int CTRL_IRQ_BIT = 6;
    localparam int CTRL_CAS_BIT = 2;
    localparam logic [DELAY_W-1:0] START_DELAY = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_CNT_LO = 2'd0,
        REG_CNT_HI = 2'd1,
        REG_CTRL   = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        DIV_1    = 2'd0,
        DIV_64   = 2'd1,
        DIV_256  = 2'd2,
        DIV_1024 = 2'd3
    } t_div;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic               tick;
        logic               wr;
        t_reg               reg_sel;
        logic [7:0]         wdata;
        logic [PRESC_W-1:0] presc;   // prescaler value after this tick
    } t_cell_cmd;

    // Output word, read_data in the low byte.
    typedef struct packed {
        logic [PULSE_W-1:0] overflow_pulse;
        logic [PULSE_W-1:0] irq_pulse;
        logic [7:0]         read_data;
    } t_result;

    function automatic logic presc_hit(t_div sel, logic [PRESC_W-1:0] p);
        logic hit;
        unique case (sel)
            DIV_1:    hit = 1'b1;
            DIV_64:   hit = (p[5:0] == 6'd0);
            DIV_256:  hit = (p[7:0] == 8'd0);
            DIV_1024: hit = (p[9:0] == 10'd0);
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/core/cpt_cell.sv -----
module cpt_cell
    import cpt_bank_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  logic      i_sel,      // this timer is addressed
    input  logic      i_first,    // timer 0: no cascade
    input  logic      i_carry,    // overflow of the timer below
    output logic      o_carry,
    output logic      o_irq,
    output logic [7:0] o_rd
);

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic [7:0]             r_ctl, n_ctl;
    logic [DELAY_W-1:0]     r_delay, n_delay;

    logic             w_bump;
    logic             w_over;
    logic [EXT_W-1:0] w_cnt_x;
    logic [EXT_W-1:0] w_rl_x;

    assign w_cnt_x = EXT_W'(r_cnt);

    always_comb begin
        w_bump = 1'b0;
        n_delay = r_delay;
        if (i_cmd.tick && r_ctl[CTRL_EN_BIT]) begin
            if (r_delay != '0) begin
                n_delay = r_delay - 1'b1;
            end else if (!i_first && r_ctl[CTRL_CAS_BIT]) begin
                w_bump = i_carry;
            end else begin
                w_bump = presc_hit(t_div'(r_ctl[1:0]), i_cmd.presc);
            end
        end
        w_over = w_bump && (r_cnt == {COUNT_WIDTH{1'b1}});

        n_cnt    = r_cnt;
        n_reload = r_reload;
        n_ctl    = r_ctl;
        w_rl_x   = EXT_W'(r_reload);
        if (w_over) begin
            n_cnt = r_reload;
        end else if (w_bump) begin
            n_cnt = r_cnt + 1'b1;
        end

        if (i_cmd.wr && i_sel) begin
            unique case (i_cmd.reg_sel)
                REG_CNT_LO: begin
                    w_rl_x[7:0] = i_cmd.wdata;
                    n_reload = w_rl_x[COUNT_WIDTH-1:0];
                end
                REG_CNT_HI: begin
                    w_rl_x[15:8] = i_cmd.wdata;
                    n_reload = w_rl_x[COUNT_WIDTH-1:0];
                end
                REG_CTRL: begin
                    // start or prescale change: reload and hold off two ticks
                    if (i_cmd.wdata[CTRL_EN_BIT] &&
                        (!r_ctl[CTRL_EN_BIT] || i_cmd.wdata[1:0] != r_ctl[1:0])) begin
                        n_cnt   = r_reload;
                        n_delay = START_DELAY;
                    end
                    n_ctl = i_cmd.wdata & (i_first ? CTRL_MASK_FIRST : CTRL_MASK_REST);
                end
                REG_UNUSED: ;
                default: ;
            endcase
        end

        unique case (i_cmd.reg_sel)
            REG_CNT_LO: o_rd = w_cnt_x[7:0];
            REG_CNT_HI: o_rd = w_cnt_x[15:8];
            REG_CTRL:   o_rd = r_ctl;
            default:    o_rd = 8'd0;
        endcase
    end

    assign o_carry = w_over;
    assign o_irq   = w_over && r_ctl[CTRL_IRQ_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_reload <= '0;
            r_ctl    <= '0;
            r_delay  <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_reload <= n_reload;
            r_ctl    <= n_ctl;
            r_delay  <= n_delay;
        end
    end

    a_no_ovf_in_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick && r_delay != '0) |-> !o_carry)
        else $error("timer overflowed while start delay pending");

    a_ovf_reloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_carry |=> (r_cnt == $past(r_reload)))
        else $error("overflow did not reload counter");

endmodule

// ----- rtl/core/cpt_skid.sv -----
module cpt_skid
    import cpt_bank_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_acc_in, w_acc_out;

    assign o_ready   = !r_skid_v;
    assign w_acc_in  = i_valid && o_ready;
    assign w_acc_out = r_out_v && i_ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (w_acc_out) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else if (w_acc_in) begin
                n_out = i_data;
            end else begin
                n_out_v = 1'b0;
            end
        end else if (w_acc_in) begin
            if (!r_out_v) begin
                n_out   = i_data;
                n_out_v = 1'b1;
            end else begin
                n_skid   = i_data;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with output register empty");

endmodule

// ----- rtl/core/cascadable_prescaled_timer_bank_core.sv -----
// Bank of NUM_TIMERS up-counters with a free-running 10-bit prescaler and
// a byte-wide register window, one command per input word.
// Slave channel: tuser carries the command (tick, byte read, byte write),
// tdata carries the register offset (timer*4 + {count lo, count hi,
// control, unused}) and the write byte. Every accepted word produces
// exactly one output word: the read byte, and on ticks the per-timer
// interrupt and overflow pulses.
// Throughput: one word per cycle while tready is high. The timers sit in a row of cells; on a
// tick the overflow of each cell feeds the cascade input of the next in
// the same cycle, so the carry ripple through the row bounds the clock.
// Each result is registered, in the skid stage if an older one waits.
// The output side has a register plus a one-word skid stage; the input
// keeps taking words while a result waits, and tready drops only once
// both stages are full.
// Reset (synchronous, active low) clears counters, reload values, control
// bytes, start delays, the prescaler and both output stages.
module cascadable_prescaled_timer_bank_core
    import cpt_bank_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [3:0] reg_offset, [11:4] write_data, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [7:0] read_data, [11:8] irq_pulse, [15:12] overflow_pulse
);

    logic               w_acc;
    t_cmd               w_cmd;
    logic [3:0]         w_off;
    logic [1:0]         w_tsel;
    logic [PRESC_W-1:0] r_presc, n_presc;
    t_cell_cmd          w_ccmd;
    logic [NUM_TIMERS:0]   w_carry;
    logic [NUM_TIMERS-1:0] w_irq_c;
    logic [7:0]         w_rd_c [NUM_TIMERS];
    logic [7:0]         w_rd;
    logic [PULSE_W-1:0] w_ovf, w_irq;
    t_result            w_res, w_out;

    assign w_acc  = i_s_tvalid && o_s_tready;
    assign w_cmd  = t_cmd'(i_s_tuser);
    assign w_off  = i_s_tdata[3:0];
    assign w_tsel = w_off[3:2];

    assign n_presc = (w_acc && w_cmd == CMD_TICK) ? r_presc + 1'b1 : r_presc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
        end else begin
            r_presc <= n_presc;
        end
    end

    assign w_ccmd.tick    = w_acc && (w_cmd == CMD_TICK);
    assign w_ccmd.wr      = w_acc && (w_cmd == CMD_WRITE);
    assign w_ccmd.reg_sel = t_reg'(w_off[1:0]);
    assign w_ccmd.wdata   = i_s_tdata[11:4];
    assign w_ccmd.presc   = n_presc;
    assign w_carry[0]     = 1'b0;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        cpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_ccmd),
            .i_sel   (32'(w_tsel) == g),
            .i_first (g == 0),
            .i_carry (w_carry[g]),
            .o_carry (w_carry[g+1]),
            .o_irq   (w_irq_c[g]),
            .o_rd    (w_rd_c[g])
        );
    end

    always_comb begin
        w_rd = 8'd0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(w_tsel) == i) begin
                w_rd = w_rd | w_rd_c[i];
            end
        end
    end

    for (genvar b = 0; b < PULSE_W; b++) begin : g_pulse
        if (b < NUM_TIMERS) begin : g_on
            assign w_ovf[b] = w_carry[b+1];
            assign w_irq[b] = w_irq_c[b];
        end else begin : g_off
            assign w_ovf[b] = 1'b0;
            assign w_irq[b] = 1'b0;
        end
    end

    assign w_res.read_data      = (w_cmd == CMD_READ) ? w_rd : 8'd0;
    assign w_res.irq_pulse      = w_irq;
    assign w_res.overflow_pulse = w_ovf;

    cpt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (w_res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    assign o_m_tdata = w_out;

    a_irq_within_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ((w_res.irq_pulse & ~w_res.overflow_pulse) == '0))
        else $error("irq pulse without overflow");

    a_pulse_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd != CMD_TICK) |-> (w_ovf == '0))
        else $error("overflow on a non-tick word");

    a_read_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd != CMD_READ) |-> (w_res.read_data == 8'd0))
        else $error("read data on a non-read word");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import cpt_bank_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;  // [3:0] reg_offset, [11:4] write_data, rest zero
    logic [1:0]  i_s_tuser = '0;  // [1:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;       // [7:0] read_data, [11:8] irq_pulse, [15:12] overflow_pulse

    cascadable_prescaled_timer_bank_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the timer bank
    logic [COUNT_WIDTH-1:0] shadow_cnt [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] shadow_rld [NUM_TIMERS];
    logic [7:0]             shadow_ctl [NUM_TIMERS];
    logic [DELAY_W-1:0]     shadow_dly [NUM_TIMERS];
    logic [PRESC_W-1:0]     shadow_presc;

    t_result pending_results[$];
    t_result got_word;
    t_result want_word;

    int err_cnt = 0;
    int words_sent = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int n_ticks = 0, n_reads = 0, n_writes = 0, n_other = 0;
    int n_ovf = 0, n_irq = 0;

    function automatic logic [3:0] reg_addr(int tm, t_reg r);
        return {tm[1:0], r};
    endfunction

    function automatic t_result timer_bank_step(t_cmd cmd, logic [3:0] off, logic [7:0] wd);
        t_result res;
        logic carry;
        logic bump;
        logic over;
        logic [7:0] c;
        int tm;
        res = '0;
        tm = off[3:2];
        case (cmd)
            CMD_TICK: begin
                shadow_presc = shadow_presc + 1'b1;
                carry = 1'b0;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    c = shadow_ctl[i];
                    bump = 1'b0;
                    over = 1'b0;
                    if (c[CTRL_EN_BIT]) begin
                        if (shadow_dly[i] != '0) begin
                            shadow_dly[i] = shadow_dly[i] - 1'b1;
                        end else if (i > 0 && c[CTRL_CAS_BIT]) begin
                            bump = carry;
                        end else begin
                            case (t_div'(c[1:0]))
                                DIV_1:   bump = 1'b1;
                                DIV_64:  bump = (shadow_presc[5:0] == '0);
                                DIV_256: bump = (shadow_presc[7:0] == '0);
                                default: bump = (shadow_presc == '0);
                            endcase
                        end
                    end
                    if (bump) begin
                        if (shadow_cnt[i] == '1) begin
                            shadow_cnt[i] = shadow_rld[i];
                            over = 1'b1;
                        end else begin
                            shadow_cnt[i] = shadow_cnt[i] + 1'b1;
                        end
                    end
                    if (over && i < PULSE_W) begin
                        res.overflow_pulse[i] = 1'b1;
                        if (c[CTRL_IRQ_BIT])
                            res.irq_pulse[i] = 1'b1;
                    end
                    carry = over;
                end
            end
            CMD_READ: begin
                if (tm < NUM_TIMERS) begin
                    case (t_reg'(off[1:0]))
                        REG_CNT_LO: res.read_data = shadow_cnt[tm][7:0];
                        REG_CNT_HI: res.read_data = shadow_cnt[tm][15:8];
                        REG_CTRL:   res.read_data = shadow_ctl[tm];
                        default:    res.read_data = 8'h00;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (tm < NUM_TIMERS) begin
                    case (t_reg'(off[1:0]))
                        REG_CNT_LO: shadow_rld[tm][7:0] = wd;
                        REG_CNT_HI: shadow_rld[tm][15:8] = wd;
                        REG_CTRL: begin
                            c = shadow_ctl[tm];
                            // enabling, or a new prescale on a running timer, restarts it
                            if (wd[CTRL_EN_BIT] && (!c[CTRL_EN_BIT] || wd[1:0] != c[1:0])) begin
                                shadow_cnt[tm] = shadow_rld[tm];
                                shadow_dly[tm] = START_DELAY;
                            end
                            shadow_ctl[tm] = wd & (tm == 0 ? CTRL_MASK_FIRST : CTRL_MASK_REST);
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        $display("[%0d] mismatch on %s: expected 'h%0h, got 'h%0h",
                 cycle_cnt, what, want_v, got_v);
        err_cnt++;
    endtask

    // Scoreboard: check outgoing words, then predict the word taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got_word = t_result'(o_m_tdata);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", 0, o_m_tdata);
                end else begin
                    want_word = pending_results.pop_front();
                    if (got_word.read_data != want_word.read_data)
                        report_mismatch("read_data", want_word.read_data, got_word.read_data);
                    if (got_word.irq_pulse != want_word.irq_pulse)
                        report_mismatch("irq_pulse", want_word.irq_pulse, got_word.irq_pulse);
                    if (got_word.overflow_pulse != want_word.overflow_pulse)
                        report_mismatch("overflow_pulse", want_word.overflow_pulse,
                                        got_word.overflow_pulse);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                want_word = timer_bank_step(t_cmd'(i_s_tuser), i_s_tdata[3:0],
                                            i_s_tdata[11:4]);
                pending_results.push_back(want_word);
                case (t_cmd'(i_s_tuser))
                    CMD_TICK:  n_ticks++;
                    CMD_READ:  n_reads++;
                    CMD_WRITE: n_writes++;
                    default:   n_other++;
                endcase
                n_ovf += $countones(want_word.overflow_pulse);
                n_irq += $countones(want_word.irq_pulse);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_cnt, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_word(t_cmd cmd, logic [3:0] off, logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {4'h0, data, off};
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed();
        // timers 0 and 1 reload at the top of the count
        send_word(CMD_WRITE, reg_addr(0, REG_CNT_LO), 8'hFF);
        send_word(CMD_WRITE, reg_addr(0, REG_CNT_HI), 8'hFF);
        send_word(CMD_WRITE, reg_addr(1, REG_CNT_LO), 8'hFF);
        send_word(CMD_WRITE, reg_addr(1, REG_CNT_HI), 8'hFF);
        // all control bits set: masked, timer 1 cascades
        send_word(CMD_WRITE, reg_addr(1, REG_CTRL), 8'hFF);
        send_word(CMD_WRITE, reg_addr(0, REG_CTRL), 8'hFF);
        // prescale change while running restarts the delay
        send_word(CMD_WRITE, reg_addr(0, REG_CTRL), 8'hC0);
        send_word(CMD_READ, reg_addr(0, REG_CTRL), 8'h00);
        // two delayed ticks, then both overflow through the cascade
        repeat (3) send_word(CMD_TICK, 4'h0, 8'h00);
        send_word(CMD_READ, reg_addr(0, REG_CNT_LO), 8'h00);
        send_word(CMD_READ, reg_addr(0, REG_CNT_HI), 8'h00);
        send_word(CMD_READ, reg_addr(1, REG_CTRL), 8'h00);
        send_word(CMD_WRITE, reg_addr(1, REG_UNUSED), 8'hAA);
        send_word(CMD_READ, reg_addr(1, REG_UNUSED), 8'h00);
        // timer 2 cascades from timer 1 while timer 1 gets disabled: chain break
        send_word(CMD_WRITE, reg_addr(2, REG_CTRL), 8'h84);
        send_word(CMD_WRITE, reg_addr(1, REG_CTRL), 8'h44);
        send_word(CMD_NONE, 4'hF, 8'hFF);
        repeat (3) send_word(CMD_TICK, 4'h0, 8'h00);
        // disabling keeps the count
        send_word(CMD_WRITE, reg_addr(0, REG_CTRL), 8'h00);
        send_word(CMD_TICK, 4'h0, 8'h00);
        send_word(CMD_READ, reg_addr(0, REG_CNT_LO), 8'h00);
        send_word(CMD_READ, reg_addr(3, REG_CNT_HI), 8'h00);
    endtask

    task automatic random_write();
        logic [3:0] off;
        logic [7:0] data;
        off  = 4'($urandom_range(15));
        data = 8'($urandom_range(255));
        if (off[1:0] == REG_CNT_HI && $urandom_range(1))
            data = $urandom_range(1) ? 8'hFF : 8'hFE;
        if (off[1:0] == REG_CTRL && $urandom_range(99) < 70)
            data[CTRL_EN_BIT] = 1'b1;
        send_word(CMD_WRITE, off, data);
    endtask

    task automatic test_random(int count);
        int stop_at;
        int r;
        int tm;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 40) begin
                repeat ($urandom_range(1, 8)) send_word(CMD_TICK, 4'($urandom_range(15)),
                                                        8'($urandom_range(255)));
            end else if (r < 55) begin
                send_word(CMD_READ, 4'($urandom_range(15)), 8'($urandom_range(255)));
            end else if (r < 75) begin
                random_write();
            end else if (r < 95) begin
                // set up one timer near the top of its count and let it run
                tm = $urandom_range(NUM_TIMERS - 1);
                send_word(CMD_WRITE, reg_addr(tm, REG_CNT_LO), 8'($urandom_range(255)));
                send_word(CMD_WRITE, reg_addr(tm, REG_CNT_HI), 8'($urandom_range(248, 255)));
                send_word(CMD_WRITE, reg_addr(tm, REG_CTRL),
                          {1'b1, 7'($urandom_range(127))});
                repeat ($urandom_range(2, 12)) send_word(CMD_TICK, 4'h0, 8'h00);
            end else begin
                send_word(CMD_NONE, 4'($urandom_range(15)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left = 300;
        repeat (40) begin
            if ($urandom_range(1))
                send_word(CMD_TICK, 4'h0, 8'h00);
            else
                send_word(CMD_READ, 4'($urandom_range(15)), 8'h00);
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            shadow_cnt[i] = '0;
            shadow_rld[i] = '0;
            shadow_ctl[i] = '0;
            shadow_dly[i] = '0;
        end
        shadow_presc = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_idling(0, 0);
        test_random(400);
        set_idling(73, 0);
        test_random(400);
        set_idling(0, 73);
        test_random(400);
        set_idling(6, 6);
        test_random(400);
        test_backpressure();

        i_s_tvalid <= 1'b0;
        set_idling(0, 0);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d ticks, %0d reads, %0d writes, %0d unknown commands",
                 n_ticks, n_reads, n_writes, n_other);
        $display("saw %0d timer overflows and %0d interrupt pulses, %0d mismatches",
                 n_ovf, n_irq, err_cnt);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/cpt_bank_pkg.sv
rtl/core/cpt_cell.sv
rtl/core/cpt_skid.sv
rtl/core/cascadable_prescaled_timer_bank_core.sv
tb/testbench.sv
